// ===== src/b64e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, codes and the alphabet lookup for the base64 line encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int unsigned ADDR_W = 3;
	localparam logic [ADDR_W-1:0] REG_FINAL_NL = 3'd0;

	localparam logic OP_DATA   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_PAD     = 8'h3D;

	typedef logic [5:0] sextet_t;

	// one queued job: up to four group characters, then an optional newline
	typedef struct packed {
		sextet_t [3:0] sext;
		logic          has_group;
		logic          pad2;
		logic          pad3;
		logic          newline;
	} b64e_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} b64e_qstat_t;

	function automatic logic [7:0] b64_char(input sextet_t idx);
		logic [7:0] c;
		begin
			if (idx < 6'd26) begin
				c = 8'h41 + {2'b00, idx};
			end else if (idx < 6'd52) begin
				c = 8'h61 + {2'b00, idx} - 8'd26;
			end else if (idx < 6'd62) begin
				c = 8'h30 + {2'b00, idx} - 8'd52;
			end else if (idx == 6'd62) begin
				c = 8'h2B;
			end else begin
				c = 8'h2F;
			end
			return c;
		end
	endfunction

endpackage

// ===== src/b64e_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_in_if / b64e_out_if
// Valid/ready channels for input items and encoded characters.
// ----------------------------------------------------------------------------
interface b64e_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface b64e_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;

	modport source (output valid, output out_char, output last, input ready);
	modport sink (input valid, input out_char, input last, output ready);
endinterface

// ===== src/b64e_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Accepts beats, holds partial groups, tracks line length, builds jobs.
// ----------------------------------------------------------------------------
module b64e_front #(
	parameter int unsigned LINE_CHARS = 76
) (
	input  logic              clk,
	input  logic              arst_n,
	b64e_in_if.sink           in_ch,
	input  logic              final_nl,
	input  b64e_pkg::b64e_qstat_t qstat,
	output logic              push,
	output b64e_pkg::b64e_job_t push_job
);
	import b64e_pkg::*;

	localparam int unsigned LW = $clog2(LINE_CHARS + 4);
	localparam logic [LW-1:0] LINE_MAX = LW'(LINE_CHARS);

	logic [7:0]    held0_q;
	logic [7:0]    held1_q;
	logic [1:0]    held_cnt_q;
	logic [LW-1:0] line_cnt_q;

	logic          accept;
	logic [7:0]    b0, b1, b2;
	logic [LW-1:0] line_sum;
	logic          wrap;
	b64e_job_t     job;
	logic          job_valid;

	assign in_ch.ready = !qstat.full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign line_sum    = line_cnt_q + LW'(4);
	assign wrap        = line_sum >= LINE_MAX;

	always_comb begin
		b0 = held0_q;
		b1 = held1_q;
		b2 = in_ch.data_byte;
		job = '0;
		job_valid = 1'b0;
		if (in_ch.opcode == OP_DATA) begin
			job.has_group = 1'b1;
			job.newline   = wrap;
			job_valid     = (held_cnt_q == 2'd2);
		end else begin
			b1 = (held_cnt_q == 2'd2) ? held1_q : 8'h00;
			b2 = 8'h00;
			job.has_group = (held_cnt_q != 2'd0);
			job.pad3      = 1'b1;
			job.pad2      = (held_cnt_q == 2'd1);
			job.newline   = final_nl && (job.has_group || line_cnt_q != '0);
			job_valid     = job.has_group || job.newline;
		end
		job.sext[0] = b0[7:2];
		job.sext[1] = {b0[1:0], b1[7:4]};
		job.sext[2] = {b1[3:0], b2[7:6]};
		job.sext[3] = b2[5:0];
	end

	assign push     = accept && job_valid;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			line_cnt_q <= '0;
		end else if (accept) begin
			if (in_ch.opcode == OP_DATA) begin
				if (held_cnt_q == 2'd2) begin
					held_cnt_q <= 2'd0;
					line_cnt_q <= wrap ? '0 : line_sum;
				end else begin
					held_cnt_q <= held_cnt_q + 2'd1;
				end
			end else begin
				held_cnt_q <= 2'd0;
				line_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_ch.opcode == OP_DATA) begin
			if (held_cnt_q == 2'd0) begin
				held0_q <= in_ch.data_byte;
			end
			if (held_cnt_q == 2'd1) begin
				held1_q <= in_ch.data_byte;
			end
		end
	end

endmodule

// ===== src/b64e_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry job queue between front and back, head visible at output.
// ----------------------------------------------------------------------------
module b64e_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64e_pkg::b64e_job_t   push_job,
	input  logic                  pop,
	output b64e_pkg::b64e_job_t   head_job,
	output b64e_pkg::b64e_qstat_t qstat
);
	import b64e_pkg::*;

	b64e_job_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);
	assign head_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== src/b64e_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head job into the output reg, one char per unstalled cycle.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b64e_pkg::b64e_job_t   head_job,
	input  b64e_pkg::b64e_qstat_t qstat,
	output logic                  pop,
	b64e_out_if.source            out_ch
);
	import b64e_pkg::*;

	logic [2:0] pos_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;

	logic       advance;
	logic       emit;
	logic       is_last;
	logic [7:0] ch;
	logic       pad;

	assign advance = !out_valid_q || out_ch.ready;
	assign emit    = advance && !qstat.empty;
	assign pop     = emit && is_last;

	always_comb begin
		pad = 1'b0;
		ch  = CHAR_NEWLINE;
		is_last = 1'b1;
		if (head_job.has_group && pos_q != 3'd4) begin
			case (pos_q)
				3'd2:    pad = head_job.pad2;
				3'd3:    pad = head_job.pad3;
				default: pad = 1'b0;
			endcase
			ch = pad ? CHAR_PAD : b64_char(head_job.sext[pos_q[1:0]]);
			is_last = (pos_q == 3'd3) && !head_job.newline;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				pos_q       <= is_last ? 3'd0 : pos_q + 3'd1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= ch;
			out_last_q <= is_last;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_char = out_char_q;
	assign out_ch.last     = out_last_q;

endmodule

// ===== src/base64_line_wrapped_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder
// Base64 encoder, standard alphabet, newline once a line reaches LINE_CHARS characters.
// ----------------------------------------------------------------------------
// One raw byte per input beat (opcode data) or a finish beat that pads,
// fills with '=' and optionally closes the line. Output is one character
// per cycle while a job is queued and out_ch is ready; last marks the final
// character that each input beat produces. Input beats are taken every cycle
// while the two-entry job queue has room, so the sustained rate is set by the
// output side: a three-byte group costs four characters, five with a newline.
// Register 0 (byte address 0): bit 0 final_newline_enable, reset 1.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder #(
	parameter int unsigned LINE_CHARS = 76
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [b64e_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	b64e_in_if.sink                       in_ch,
	b64e_out_if.source                    out_ch
);
	import b64e_pkg::*;

	logic        final_nl_q;
	logic        push;
	logic        pop;
	b64e_job_t   push_job;
	b64e_job_t   head_job;
	b64e_qstat_t qstat;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_FINAL_NL) ? {31'd0, final_nl_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_nl_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr == REG_FINAL_NL) begin
			final_nl_q <= pwdata[0];
		end
	end

	b64e_front #(
		.LINE_CHARS (LINE_CHARS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.final_nl (final_nl_q),
		.qstat    (qstat),
		.push     (push),
		.push_job (push_job)
	);

	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.qstat    (qstat)
	);

	b64e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.qstat    (qstat),
		.pop      (pop),
		.out_ch   (out_ch)
	);

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for base64_line_wrapped_encoder. A scoreboard model
// encodes every accepted input beat and queues the characters it expects;
// each output beat is checked in order against that queue. Directed beats
// cover the alphabet ends, padding and the final-newline register, then
// random byte streams run under both register settings, with and without
// random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import b64e_pkg::*;

	localparam int unsigned LINE_LEN = 76;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam logic [8*64-1:0] SYMBOLS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} enc_char_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	b64e_in_if  in_ch ();
	b64e_out_if out_ch ();

	base64_line_wrapped_encoder #(.LINE_CHARS(LINE_LEN)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	// encoder model state
	logic [7:0] held_byte [2] = '{8'h00, 8'h00};
	int         held_num = 0;
	int         line_len = 0;
	logic       nl_enable = 1'b1;

	enc_char_t  pending_chars [$];
	int         errors = 0;
	int         quiet_cycles = 0;
	bit         idle_en = 1'b1;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [7:0] b64_symbol(input logic [5:0] v);
		return SYMBOLS[8*(63 - v) +: 8];
	endfunction

	function automatic void predict_beat(input logic op, input logic [7:0] b);
		logic [7:0] gb0;
		logic [7:0] gb1;
		logic [7:0] gb2;
		logic [5:0] sx [4];
		int         pads;
		bit         do_group;
		bit         do_nl;
		enc_char_t  grp [$];
		enc_char_t  e;
		do_group = 1'b0;
		do_nl = 1'b0;
		pads = 0;
		gb0 = 8'h00;
		gb1 = 8'h00;
		gb2 = 8'h00;
		if (op == OP_DATA) begin
			if (held_num < 2) begin
				held_byte[held_num] = b;
				held_num++;
			end else begin
				do_group = 1'b1;
				gb0 = held_byte[0];
				gb1 = held_byte[1];
				gb2 = b;
				held_num = 0;
				line_len += 4;
				if (line_len >= LINE_LEN) begin
					do_nl = 1'b1;
					line_len = 0;
				end
			end
		end else begin
			if (held_num != 0) begin
				do_group = 1'b1;
				gb0 = held_byte[0];
				gb1 = (held_num == 2) ? held_byte[1] : 8'h00;
				pads = 3 - held_num;
				line_len += 4;
			end
			if (line_len > 0 && nl_enable)
				do_nl = 1'b1;
			held_byte[0] = 8'h00;
			held_byte[1] = 8'h00;
			held_num = 0;
			line_len = 0;
		end
		if (do_group) begin
			sx[0] = gb0[7:2];
			sx[1] = {gb0[1:0], gb1[7:4]};
			sx[2] = {gb1[3:0], gb2[7:6]};
			sx[3] = gb2[5:0];
			for (int k = 0; k < 4; k++) begin
				e.ch = (k >= 4 - pads) ? CHAR_PAD : b64_symbol(sx[k]);
				e.last = 1'b0;
				grp.push_back(e);
			end
		end
		if (do_nl) begin
			e.ch = CHAR_NEWLINE;
			e.last = 1'b0;
			grp.push_back(e);
		end
		if (grp.size() > 0)
			grp[grp.size() - 1].last = 1'b1;
		foreach (grp[i])
			pending_chars.push_back(grp[i]);
	endfunction

	// beat monitor, scoreboard and watchdog
	always @(posedge clk) begin
		enc_char_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				predict_beat(in_ch.opcode, in_ch.data_byte);
			if (out_ch.valid && out_ch.ready) begin
				if (pending_chars.size() == 0) begin
					errors++;
					$display("%0t: unexpected char: expected none, actual %h last %b",
						$time, out_ch.out_char, out_ch.last);
				end else begin
					want = pending_chars.pop_front();
					if (out_ch.out_char !== want.ch) begin
						errors++;
						$display("%0t: out_char mismatch: expected %h, actual %h",
							$time, want.ch, out_ch.out_char);
					end
					if (out_ch.last !== want.last) begin
						errors++;
						$display("%0t: last mismatch: expected %b, actual %b",
							$time, want.last, out_ch.last);
					end
				end
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	always @(negedge clk)
		out_ch.ready <= !(idle_en && $urandom_range(99) < 23);

	// all tasks below are entered and left at a falling edge
	task automatic send_item(input logic op, input logic [7:0] b);
		while (idle_en && $urandom_range(99) < 23) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.data_byte <= b;
		@(posedge clk);
		while (!(in_ch.valid && in_ch.ready))
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_encoder;
		in_ch.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_final_newline(input logic en);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_FINAL_NL;
		pwdata <= {31'd0, en};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		nl_enable = en;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[0] !== en) begin
			errors++;
			$display("%0t: register readback: expected %b, actual %b",
				$time, en, prdata[0]);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_directed;
		idle_en = 1'b1;
		// finish on an empty stream
		send_item(OP_FINISH, 8'hFF);
		send_item(OP_DATA, 8'h00);
		send_item(OP_DATA, 8'h00);
		send_item(OP_DATA, 8'h00);
		send_item(OP_DATA, 8'hFF);
		send_item(OP_DATA, 8'hFF);
		send_item(OP_DATA, 8'hFF);
		// '+' and '/'
		send_item(OP_DATA, 8'hFB);
		send_item(OP_DATA, 8'hFF);
		send_item(OP_DATA, 8'hBF);
		// one byte left, then two bytes left
		send_item(OP_DATA, 8'hA5);
		send_item(OP_FINISH, 8'hFF);
		send_item(OP_DATA, 8'h5A);
		send_item(OP_DATA, 8'hC3);
		send_item(OP_FINISH, 8'h00);
		send_item(OP_FINISH, 8'h55);
		drain_encoder();
		write_final_newline(1'b0);
		send_item(OP_DATA, 8'h80);
		send_item(OP_FINISH, 8'hAA);
		send_item(OP_DATA, 8'h01);
		send_item(OP_DATA, 8'h7F);
		send_item(OP_DATA, 8'hFE);
		send_item(OP_FINISH, 8'h00);
	endtask

	task automatic test_random_streams(input logic en, input bit idling, input int n_items);
		int sent;
		int len;
		drain_encoder();
		write_final_newline(en);
		idle_en = idling;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 8) begin
				send_item(OP_FINISH, 8'($urandom));
				sent++;
			end else begin
				len = ($urandom_range(9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
				if (sent + len + 1 > n_items)
					len = n_items - sent - 1;
				for (int k = 0; k < len; k++)
					send_item(OP_DATA, 8'($urandom));
				send_item(OP_FINISH, 8'($urandom));
				sent += len + 1;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_DATA;
		in_ch.data_byte = 8'h00;
		out_ch.ready = 1'b1;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_streams(1'b0, 1'b1, 120);
		test_random_streams(1'b1, 1'b0, 110);
		test_random_streams(1'b1, 1'b1, 130);

		in_ch.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== base64_line_wrapped_encoder.f =====
src/b64e_pkg.sv
src/b64e_if.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_line_wrapped_encoder.sv
verif/testbench.sv
